// ----- sv/mhjs_pkg.sv -----
// shared types, constants and codes for the min-heap job scheduler
`default_nettype none

package mhjs_pkg;

  // heap geometry
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 11;
  localparam int KEY_W    = 40;
  localparam int TIME_W   = 32;

  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAPACITY);

  // command codes
  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_SCHEDULE = 2'd1;
  localparam logic [1:0] CMD_EXTRACT  = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_CHK,
    ST_DN_RD,
    ST_DN_CMP,
    ST_SUM,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DONE
  } state_t;

  // request handed to the heap core
  typedef struct packed {
    logic [1:0]        cmd;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] duration;
    logic [CNT_W-1:0]  cap;
  } req_t;

  // result handed back by the heap core
  typedef struct packed {
    logic [KEY_W-1:0] value;
    logic [1:0]       status;
    logic [CNT_W-1:0] entries_held;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/min_heap_job_scheduler_unit.sv -----
// top level of the min-heap job scheduler: handshakes, capacity register, result register
//
// channel   signals                        moves
// -------   ----------------------------   -----------------------------------------
// in        in_valid / in_ready            cmd, key, arrival_time, duration
// out       out_valid / out_ready          value, status, entries_held
// cfg       cfg_wr_en / cfg_wr_data        capacity, no wait, no read-back
//
// one request at a time; each heap level passes through the single sift
// unit as a read of the slot, then a compare and write. errors and cmd 3
// go straight to the result without touching the heap.
// rst clears the entry count and the sequencer, capacity returns to 1024.
// a result waits in the output register while the next request is taken.
`default_nettype none

module min_heap_job_scheduler_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          cmd,
  input  logic [mhjs_pkg::KEY_W-1:0]          key,
  input  logic [mhjs_pkg::TIME_W-1:0]         arrival_time,
  input  logic [mhjs_pkg::TIME_W-1:0]         duration,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mhjs_pkg::KEY_W-1:0]          value,
  output logic [1:0]                          status,
  output logic [mhjs_pkg::CNT_W-1:0]          entries_held,
  input  logic                                cfg_wr_en,
  input  logic [mhjs_pkg::CNT_W-1:0]          cfg_wr_data
);
  import mhjs_pkg::*;

  logic             active_capacity;
  logic [CNT_W-1:0] capacity;
  logic [CNT_W-1:0] cap_eff;
  logic             start;
  logic             core_idle;
  logic             res_valid;
  logic             res_take;
  req_t             req;
  res_t             res;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_MAX;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // capacity beyond the store saturates
  assign active_capacity = capacity > CAP_MAX;
  assign cap_eff         = active_capacity ? CAP_MAX : capacity;

  // request into the core
  assign in_ready         = core_idle;
  assign start            = in_valid && in_ready;
  assign req.cmd          = cmd;
  assign req.key          = key;
  assign req.arrival_time = arrival_time;
  assign req.duration     = duration;
  assign req.cap          = cap_eff;

  mhjs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output register
  assign res_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      value        <= res.value;
      status       <= res.status;
      entries_held <= res.entries_held;
    end
  end

  // a taken request blocks the input until the core finishes
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("input ready right after a request was taken");

  // core never offers a result while idle
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !(core_idle && res_valid))
    else $error("core idle with a result pending");

  // error results carry a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |-> (value == '0))
    else $error("error result with nonzero value");

  // entry count never exceeds the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entries_held <= CAP_MAX))
    else $error("entry count beyond capacity");

endmodule

`default_nettype wire

// ----- sv/mhjs_core.sv -----
// heap store and sift sequencer for the min-heap job scheduler
`default_nettype none

module mhjs_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mhjs_pkg::req_t req,
  output logic           idle,
  output logic           res_valid,
  input  logic           res_take,
  output mhjs_pkg::res_t res
);
  import mhjs_pkg::*;

  state_t state, state_next;

  // heap store, one write and two registered reads
  logic [KEY_W-1:0]  mem [CAPACITY];
  logic [KEY_W-1:0]  rd0, rd1;
  logic [ADDR_W-1:0] raddr0, raddr1, waddr;
  logic              we;
  logic [KEY_W-1:0]  wdata;

  // datapath registers
  logic [1:0]        cmd_q, cmd_q_next;
  logic [TIME_W-1:0] arr_q, arr_q_next;
  logic [TIME_W-1:0] dur_q, dur_q_next;
  logic [KEY_W-1:0]  carry, carry_next;
  logic [KEY_W-1:0]  top, top_next;
  logic [KEY_W-1:0]  value, value_next;
  logic [1:0]        status, status_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [CNT_W-1:0]  count, count_next;

  // shared datapath terms
  logic [ADDR_W+1:0] lchild, rchild;
  logic              l_ok, r_ok, sel_l, sel_r, move, up_stop, full;
  logic [KEY_W-1:0]  cand, base, sat;
  logic [KEY_W:0]    sum;
  logic [ADDR_W-1:0] parent;
  logic [CNT_W-1:0]  cnt_dec, cnt_inc;

  // child and parent slots of the hole
  assign lchild  = {1'b0, idx, 1'b0} + (ADDR_W+2)'(1);
  assign rchild  = lchild + (ADDR_W+2)'(1);
  assign l_ok    = lchild < (ADDR_W+2)'(count);
  assign r_ok    = rchild < (ADDR_W+2)'(count);
  assign parent  = (idx - ADDR_W'(1)) >> 1;
  assign cnt_dec = count - CNT_W'(1);
  assign cnt_inc = count + CNT_W'(1);
  assign full    = count >= req.cap;

  // sift down choice, left child wins a tie
  assign sel_l   = l_ok && (carry > rd0);
  assign cand    = sel_l ? rd0 : carry;
  assign sel_r   = r_ok && (cand > rd1);
  assign move    = sel_l || sel_r;

  // sift up stops at a parent not above the key
  assign up_stop = rd0 <= carry;

  // finish time, saturated
  assign base = (top > KEY_W'(arr_q)) ? top : KEY_W'(arr_q);
  assign sum  = {1'b0, base} + (KEY_W+1)'(dur_q);
  assign sat  = sum[KEY_W] ? KEY_MAX : sum[KEY_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (req.cmd)
            CMD_INSERT:   state_next = full ? ST_DONE : ST_UP_RD;
            CMD_SCHEDULE,
            CMD_EXTRACT:  state_next = (count == '0) ? ST_DONE : ST_POP_CHK;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_POP_CHK: begin
        if (count != '0) state_next = ST_DN_RD;
        else state_next = (cmd_q == CMD_SCHEDULE) ? ST_SUM : ST_DONE;
      end
      ST_DN_RD:  state_next = ST_DN_CMP;
      ST_DN_CMP: begin
        if (move) state_next = ST_DN_RD;
        else state_next = (cmd_q == CMD_SCHEDULE) ? ST_SUM : ST_DONE;
      end
      ST_SUM:    state_next = ST_UP_RD;
      ST_UP_RD:  state_next = (idx == '0) ? ST_DONE : ST_UP_CMP;
      ST_UP_CMP: state_next = up_stop ? ST_DONE : ST_UP_RD;
      ST_DONE:   state_next = res_take ? ST_IDLE : ST_DONE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory control and datapath updates
  always_comb begin
    raddr0      = '0;
    raddr1      = '0;
    we          = 1'b0;
    waddr       = idx;
    wdata       = carry;
    cmd_q_next  = cmd_q;
    arr_q_next  = arr_q;
    dur_q_next  = dur_q;
    carry_next  = carry;
    top_next    = top;
    value_next  = value;
    status_next = status;
    idx_next    = idx;
    count_next  = count;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd_q_next  = req.cmd;
          arr_q_next  = req.arrival_time;
          dur_q_next  = req.duration;
          value_next  = '0;
          status_next = STATUS_OK;
          case (req.cmd)
            CMD_INSERT: begin
              if (full) begin
                status_next = STATUS_FULL;
              end else begin
                carry_next = req.key;
                idx_next   = count[ADDR_W-1:0];
                count_next = cnt_inc;
              end
            end
            CMD_SCHEDULE,
            CMD_EXTRACT: begin
              if (count == '0) begin
                status_next = STATUS_EMPTY;
              end else begin
                raddr0     = '0;
                raddr1     = cnt_dec[ADDR_W-1:0];
                count_next = cnt_dec;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP_CHK: begin
        // root and last entry have arrived
        top_next = rd0;
        if (count != '0) begin
          carry_next = rd1;
          idx_next   = '0;
        end else begin
          value_next = rd0;
        end
      end
      ST_DN_RD: begin
        raddr0 = lchild[ADDR_W-1:0];
        raddr1 = rchild[ADDR_W-1:0];
      end
      ST_DN_CMP: begin
        we = 1'b1;
        if (move) begin
          wdata    = sel_r ? rd1 : rd0;
          idx_next = sel_r ? rchild[ADDR_W-1:0] : lchild[ADDR_W-1:0];
        end else begin
          wdata      = carry;
          value_next = top;
        end
      end
      ST_SUM: begin
        carry_next = sat;
        idx_next   = count[ADDR_W-1:0];
        count_next = cnt_inc;
      end
      ST_UP_RD: begin
        raddr0 = parent;
        if (idx == '0) begin
          we         = 1'b1;
          wdata      = carry;
          value_next = carry;
        end
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (up_stop) begin
          wdata      = carry;
          value_next = carry;
        end else begin
          wdata    = rd0;
          idx_next = parent;
        end
      end
      default: begin
      end
    endcase
  end

  // heap store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd0 <= mem[raddr0];
    rd1 <= mem[raddr1];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_q  <= cmd_q_next;
    arr_q  <= arr_q_next;
    dur_q  <= dur_q_next;
    carry  <= carry_next;
    top    <= top_next;
    value  <= value_next;
    status <= status_next;
    idx    <= idx_next;
  end

  assign idle             = state == ST_IDLE;
  assign res_valid        = state == ST_DONE;
  assign res.value        = value;
  assign res.status       = status;
  assign res.entries_held = count;

endmodule

`default_nettype wire

// ----- test/min_heap_job_scheduler_unit_tb.sv -----
// self-checking testbench for the min-heap job scheduler unit
`timescale 1ns / 100ps

module min_heap_job_scheduler_unit_tb;
  import mhjs_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_DIRECTED = 25;
  localparam int RANDOM_ITEMS = 420;
  localparam int FILL_DEPTH   = 64;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 3000;
  localparam int IDLE_PCT     = 34;

  // one row of the directed table; want is used only where typed is set
  typedef struct packed {
    logic              cfg_wr;
    logic [CNT_W-1:0]  cfg_val;
    logic [1:0]        op;
    logic [KEY_W-1:0]  k;
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] dur;
    logic              typed;
    res_t              want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        cmd;
  logic [KEY_W-1:0]  key;
  logic [TIME_W-1:0] arrival_time;
  logic [TIME_W-1:0] duration;
  logic              out_valid;
  logic              out_ready;
  logic [KEY_W-1:0]  value;
  logic [1:0]        status;
  logic [CNT_W-1:0]  entries_held;
  logic              cfg_wr_en;
  logic [CNT_W-1:0]  cfg_wr_data;

  // mirror of the machine free times and the capacity register
  logic [KEY_W-1:0] free_times [0:CAPACITY-1];
  int unsigned      free_count;
  logic [CNT_W-1:0] machine_cap;

  res_t        owed[$];
  plan_row_t   plan [0:NUM_DIRECTED-1];
  bit          ready_hold = 1'b0;
  bit          no_idle = 1'b0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          requests_taken = 0;
  int          full_seen = 0;
  int          empty_seen = 0;
  int          depth_peak = 0;
  int          quiet = 0;

  min_heap_job_scheduler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .key          (key),
    .arrival_time (arrival_time),
    .duration     (duration),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .status       (status),
    .entries_held (entries_held),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // swap two heap slots
  function automatic void swap_free(int unsigned p, int unsigned q);
    logic [KEY_W-1:0] t;
    t = free_times[p];
    free_times[p] = free_times[q];
    free_times[q] = t;
  endfunction

  // append a free time and sift it up past strictly larger parents
  function automatic void heap_push(logic [KEY_W-1:0] k);
    int unsigned i;
    int unsigned p;
    bit          done;
    i = free_count;
    free_times[i] = k;
    free_count = i + 1;
    done = 1'b0;
    while (i > 0 && !done) begin
      p = (i - 1) / 2;
      if (free_times[p] <= free_times[i]) begin
        done = 1'b1;
      end else begin
        swap_free(p, i);
        i = p;
      end
    end
  endfunction

  // take the root, move the last entry up, sift down (left child wins ties)
  function automatic logic [KEY_W-1:0] heap_pop();
    logic [KEY_W-1:0] top;
    int unsigned      n;
    int unsigned      i;
    int unsigned      l;
    int unsigned      r;
    int unsigned      m;
    bit               done;
    top = free_times[0];
    free_count = free_count - 1;
    n = free_count;
    if (n != 0) begin
      free_times[0] = free_times[n];
      i = 0;
      done = 1'b0;
      while (!done) begin
        l = 2 * i + 1;
        r = l + 1;
        m = i;
        if (l < n && free_times[m] > free_times[l]) m = l;
        if (r < n && free_times[m] > free_times[r]) m = r;
        if (m == i) begin
          done = 1'b1;
        end else begin
          swap_free(i, m);
          i = m;
        end
      end
    end
    return top;
  endfunction

  // carry out one command on the mirror and return the result it gives
  function automatic res_t apply_command(logic [1:0] op, logic [KEY_W-1:0] k,
                                         logic [TIME_W-1:0] a, logic [TIME_W-1:0] d);
    res_t             r;
    int unsigned      lim;
    logic [KEY_W-1:0] t;
    logic [KEY_W:0]   sum;
    logic [KEY_W:0]   addend;
    lim = (machine_cap > CAP_MAX) ? CAPACITY : 32'(machine_cap);
    r.value = '0;
    r.status = STATUS_OK;
    case (op)
      CMD_INSERT: begin
        if (free_count >= lim) begin
          r.status = STATUS_FULL;
        end else begin
          heap_push(k);
          r.value = k;
        end
      end
      CMD_SCHEDULE: begin
        if (free_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          t = heap_pop();
          if (t < KEY_W'(a)) t = KEY_W'(a);
          sum = {1'b0, t};
          addend = (KEY_W+1)'(d);
          sum = sum + addend;
          t = (sum > KEY_MAX) ? KEY_MAX : sum[KEY_W-1:0];
          heap_push(t);
          r.value = t;
        end
      end
      CMD_EXTRACT: begin
        if (free_count == 0) r.status = STATUS_EMPTY;
        else r.value = heap_pop();
      end
      default: ;
    endcase
    r.entries_held = CNT_W'(free_count);
    return r;
  endfunction

  function automatic plan_row_t plan_row(logic cw, logic [CNT_W-1:0] cv, logic [1:0] op,
                                         logic [KEY_W-1:0] k, logic [TIME_W-1:0] a,
                                         logic [TIME_W-1:0] d, logic typed,
                                         logic [KEY_W-1:0] v, logic [1:0] st,
                                         logic [CNT_W-1:0] cnt);
    plan_row_t row;
    row.cfg_wr = cw;
    row.cfg_val = cv;
    row.op = op;
    row.k = k;
    row.arr = a;
    row.dur = d;
    row.typed = typed;
    row.want.value = v;
    row.want.status = st;
    row.want.entries_held = cnt;
    return row;
  endfunction

  // keys mostly small so that ties are common, some full width, some near the top
  function automatic logic [KEY_W-1:0] rand_key();
    int unsigned s;
    logic [63:0] wide;
    s = $urandom_range(0, 9);
    wide = {$urandom, $urandom};
    if (s < 6) return KEY_W'($urandom_range(0, 20));
    if (s == 6) return KEY_MAX - KEY_W'($urandom_range(0, 3));
    return wide[KEY_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    int unsigned s;
    s = $urandom_range(0, 9);
    if (s < 6) return $urandom_range(0, 40);
    if (s == 6) return '1;
    if (s == 7) return '0;
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_cmd(bit grow);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return CMD_UNUSED;
    if (grow) begin
      if (r < 50) return CMD_INSERT;
      if (r < 80) return CMD_SCHEDULE;
    end else begin
      if (r < 25) return CMD_INSERT;
      if (r < 55) return CMD_SCHEDULE;
    end
    return CMD_EXTRACT;
  endfunction

  // offer one request, wait for the handshake, then record what it owes
  task automatic send_req(logic [1:0] op, logic [KEY_W-1:0] k, logic [TIME_W-1:0] a,
                          logic [TIME_W-1:0] d, bit typed, res_t want);
    res_t due;
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = op;
    key = k;
    arrival_time = a;
    duration = d;
    do @(posedge clk); while (!in_ready);
    due = apply_command(op, k, a, d);
    if (typed) due = want;
    owed.push_back(due);
    requests_taken++;
    if (due.status == STATUS_FULL) full_seen++;
    if (due.status == STATUS_EMPTY) empty_seen++;
    if (free_count > depth_peak) depth_peak = free_count;
  endtask

  // stop offering and wait until every owed result has come back
  task automatic settle_heap();
    @(negedge clk);
    in_valid = 1'b0;
    while (owed.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // capacity write, only while the block is idle
  task automatic set_capacity(logic [CNT_W-1:0] v);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    machine_cap = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (ready_hold) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        ready_hold = 1'b0;
      end else begin
        out_ready = no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        @(negedge clk);
      end
    end
  end

  // result checker against the oldest owed result
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (owed.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result value=%h status=%0d entries_held=%0d",
                 $time, value, status, entries_held);
      end else begin
        want = owed.pop_front();
        if (value !== want.value) begin
          mismatches++;
          $display("%0t: value expected %h actual %h", $time, want.value, value);
        end
        if (status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        end
        if (entries_held !== want.entries_held) begin
          mismatches++;
          $display("%0t: entries_held expected %0d actual %0d",
                   $time, want.entries_held, entries_held);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results owed",
                 $time, STALL_LIMIT, owed.size());
        $display("min_heap_job_scheduler_unit_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int          sent_rand;
    int          ph;
    int          plen;
    int unsigned sel;
    bit          grow;
    logic [CNT_W-1:0] cap_pick;

    in_valid = 1'b0;
    cmd = CMD_INSERT;
    key = '0;
    arrival_time = '0;
    duration = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    free_count = 0;
    machine_cap = CAP_MAX;

    // directed table: empty errors, unused command, field extremes,
    // capacity below count, zero and oversized capacity, saturation
    plan[0]  = plan_row(0, 0, CMD_EXTRACT, 0, 0, 0, 1, 0, STATUS_EMPTY, 0);
    plan[1]  = plan_row(0, 0, CMD_SCHEDULE, 0, '1, '1, 1, 0, STATUS_EMPTY, 0);
    plan[2]  = plan_row(0, 0, CMD_UNUSED, KEY_MAX, '1, '1, 1, 0, STATUS_OK, 0);
    plan[3]  = plan_row(0, 0, CMD_INSERT, KEY_MAX, 0, 0, 1, KEY_MAX, STATUS_OK, 1);
    plan[4]  = plan_row(0, 0, CMD_INSERT, 0, '1, '1, 1, 0, STATUS_OK, 2);
    plan[5]  = plan_row(0, 0, CMD_INSERT, 40'h55_5555_5555, 0, 0, 1,
                        40'h55_5555_5555, STATUS_OK, 3);
    plan[6]  = plan_row(0, 0, CMD_INSERT, 40'hAA_AAAA_AAAA, 0, 0, 1,
                        40'hAA_AAAA_AAAA, STATUS_OK, 4);
    plan[7]  = plan_row(0, 0, CMD_SCHEDULE, 0, '1, '1, 0, 0, 0, 0);
    plan[8]  = plan_row(0, 0, CMD_SCHEDULE, 0, 0, 0, 0, 0, 0, 0);
    plan[9]  = plan_row(0, 0, CMD_EXTRACT, 0, 0, 0, 0, 0, 0, 0);
    plan[10] = plan_row(0, 0, CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0);
    plan[11] = plan_row(1, 2, CMD_INSERT, 1, 0, 0, 1, 0, STATUS_FULL, 3);
    plan[12] = plan_row(0, 0, CMD_SCHEDULE, 0, 3, 5, 0, 0, 0, 0);
    plan[13] = plan_row(0, 0, CMD_EXTRACT, 0, 0, 0, 0, 0, 0, 0);
    plan[14] = plan_row(0, 0, CMD_INSERT, 7, 0, 0, 1, 0, STATUS_FULL, 2);
    plan[15] = plan_row(1, 0, CMD_INSERT, 9, 0, 0, 1, 0, STATUS_FULL, 2);
    plan[16] = plan_row(0, 0, CMD_EXTRACT, 0, 0, 0, 0, 0, 0, 0);
    plan[17] = plan_row(0, 0, CMD_EXTRACT, 0, 0, 0, 0, 0, 0, 0);
    plan[18] = plan_row(0, 0, CMD_EXTRACT, 0, 0, 0, 1, 0, STATUS_EMPTY, 0);
    plan[19] = plan_row(1, '1, CMD_INSERT, KEY_MAX - 2, 0, 0, 1,
                        KEY_MAX - 2, STATUS_OK, 1);
    plan[20] = plan_row(0, 0, CMD_SCHEDULE, 0, 0, '1, 1, KEY_MAX, STATUS_OK, 1);
    plan[21] = plan_row(0, 0, CMD_INSERT, 40'h12_3456_789A, 0, 0, 0, 0, 0, 0);
    plan[22] = plan_row(1, 1, CMD_INSERT, 5, 0, 0, 1, 0, STATUS_FULL, 2);
    plan[23] = plan_row(0, 0, CMD_SCHEDULE, 0, 32'h8000_0000, 1, 0, 0, 0, 0);
    plan[24] = plan_row(1, CAP_MAX, CMD_EXTRACT, 0, 0, 0, 0, 0, 0, 0);

    // reset
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (plan[i].cfg_wr) begin
        settle_heap();
        set_capacity(plan[i].cfg_val);
      end
      send_req(plan[i].op, plan[i].k, plan[i].arr, plan[i].dur, plan[i].typed,
               plan[i].want);
    end

    // random phases, each under its own capacity
    sent_rand = 0;
    ph = 0;
    while (sent_rand < RANDOM_ITEMS) begin
      settle_heap();
      sel = $urandom_range(0, 9);
      case (sel)
        0: cap_pick = '0;
        1: cap_pick = CNT_W'(1);
        2: cap_pick = CNT_W'($urandom_range(CAPACITY + 1, 2047));
        3: cap_pick = CAP_MAX;
        4: cap_pick = (free_count > 1) ? CNT_W'($urandom_range(1, free_count - 1))
                                       : CNT_W'(3);
        default: cap_pick = CNT_W'($urandom_range(2, 24));
      endcase
      set_capacity(cap_pick);
      plen = $urandom_range(15, 45);
      // long receiver hold-off while requests keep coming
      if (ph == 1) begin
        ready_hold = 1'b1;
        plen = 40;
      end
      // one stretch with no idling on either side
      no_idle = (ph == 3);
      if (ph == 3) plen = 60;
      grow = ($urandom_range(0, 2) != 0);
      for (int n = 0; n < plen; n++) begin
        send_req(pick_cmd(grow), rand_key(), rand_time(), rand_time(), 1'b0, '0);
        sent_rand++;
      end
      no_idle = 1'b0;
      ph++;
    end

    // build a deeper heap at the largest capacity, then work it down
    settle_heap();
    set_capacity(CAP_MAX);
    while (free_count < FILL_DEPTH)
      send_req(CMD_INSERT, rand_key(), 0, 0, 1'b0, '0);
    repeat (2) send_req(CMD_INSERT, rand_key(), 0, 0, 1'b0, '0);
    repeat (8) send_req(CMD_SCHEDULE, 0, rand_time(), rand_time(), 1'b0, '0);
    repeat (30) send_req(pick_cmd(1'b0), rand_key(), rand_time(), rand_time(), 1'b0, '0);

    // drain and let any stray result show up
    settle_heap();
    repeat (60) @(negedge clk);
    if (owed.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, owed.size());
    end

    $display("summary: %0d requests, %0d results checked, %0d phases of capacity",
             requests_taken, results_seen, ph + 1);
    $display("summary: %0d heap-full and %0d heap-empty errors, depth reached %0d",
             full_seen, empty_seen, depth_peak);
    if (mismatches == 0) begin
      $display("min_heap_job_scheduler_unit_tb: PASS");
    end else begin
      $display("min_heap_job_scheduler_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/mhjs_pkg.sv
sv/mhjs_core.sv
sv/min_heap_job_scheduler_unit.sv
test/min_heap_job_scheduler_unit_tb.sv
